FILE: rtl/core/mexp_pkg.sv
// Package for the modular exponentiation unit.
// Holds the controller state codes and the multiplier status struct.
`default_nettype none
package mexp_pkg;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_BASE = 5'b00010,
        S_SQ   = 5'b00100,
        S_MUL  = 5'b01000,
        S_FIN  = 5'b10000
    } mexp_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mexp_mul_stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/modular_exponentiation_32_unit.sv
// Modular exponentiation unit: result = message^exponent mod modulus.
// One item at a time, set by the single shared bit-serial multiplier.
// A zero modulus gives result 0 with bad_modulus set; the item goes straight to S_FIN.
// Reset is asynchronous and active low; both registers reset to zero.
// Uses mexp_pkg, mexp_mul and mexp_cell.
`default_nettype none
module modular_exponentiation_32_unit
    import mexp_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [((WORD_BITS > 32) ? 4 : 3)-1:0] paddr,
    input  wire logic [((WORD_BITS > 32) ? 64 : 32)-1:0] pwdata,
    output logic [((WORD_BITS > 32) ? 64 : 32)-1:0]    prdata,
    output logic                                       pready,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic [WORD_BITS-1:0]                  message,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic [WORD_BITS-1:0]                       result,
    output logic                                       bad_modulus
);

    localparam int W  = WORD_BITS;
    localparam int AW = (W > 32) ? 4 : 3;
    localparam int CW = $clog2(W);

    localparam logic REG_MODULUS  = 1'b0;
    localparam logic REG_EXPONENT = 1'b1;

    logic [W-1:0]   modulus_reg;
    logic [W-1:0]   exponent_reg;
    mexp_state_t    state_reg;
    mexp_state_t    state_next;
    logic [W-1:0]   base_reg;
    logic [W-1:0]   base_next;
    logic [W-1:0]   r_reg;
    logic [W-1:0]   r_next;
    logic           bad_reg;
    logic           bad_next;
    logic [CW-1:0]  ebit_reg;
    logic [CW-1:0]  ebit_next;
    logic [W-1:0]   res_reg;
    logic           res_bad_reg;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic           load_out;
    logic           mstart;
    logic [W-1:0]   ma;
    logic [W-1:0]   mb;
    logic [W-1:0]   prod;
    logic [W-1:0]   one_w;
    logic [W-1:0]   r_init;
    logic           wr_en;
    logic           reg_idx;
    mexp_mul_stat_t mstat;

    assign one_w   = {{(W-1){1'b0}}, 1'b1};
    assign r_init  = (modulus_reg == one_w) ? '0 : one_w;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[AW-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= '0;
            exponent_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_MODULUS:  modulus_reg  <= pwdata[W-1:0];
                REG_EXPONENT: exponent_reg <= pwdata[W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (reg_idx)
            REG_MODULUS:  prdata[W-1:0] = modulus_reg;
            REG_EXPONENT: prdata[W-1:0] = exponent_reg;
            default:      prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    mexp_mul #(.W(W)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mstart),
        .a     (ma),
        .b     (mb),
        .n     (modulus_reg),
        .prod  (prod),
        .stat  (mstat)
    );

    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        r_next         = r_reg;
        bad_next       = bad_reg;
        ebit_next      = ebit_reg;
        mstart         = 1'b0;
        ma             = prod;
        mb             = prod;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg & out_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (modulus_reg == '0)
                    begin
                        r_next     = '0;
                        bad_next   = 1'b1;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        bad_next   = 1'b0;
                        mstart     = 1'b1;
                        ma         = one_w;
                        mb         = message;
                        state_next = S_BASE;
                    end
                end
            end
            S_BASE:
            begin
                if (mstat.done)
                begin
                    base_next  = prod;
                    r_next     = r_init;
                    ebit_next  = CW'(W-1);
                    mstart     = 1'b1;
                    ma         = r_init;
                    mb         = r_init;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                if (mstat.done)
                begin
                    r_next = prod;
                    if (exponent_reg[ebit_reg])
                    begin
                        mstart     = 1'b1;
                        ma         = prod;
                        mb         = base_reg;
                        state_next = S_MUL;
                    end
                    else if (ebit_reg == '0)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        ebit_next = ebit_reg - 1'b1;
                        mstart    = 1'b1;
                    end
                end
            end
            S_MUL:
            begin
                if (mstat.done)
                begin
                    r_next = prod;
                    if (ebit_reg == '0)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        ebit_next  = ebit_reg - 1'b1;
                        mstart     = 1'b1;
                        state_next = S_SQ;
                    end
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            ebit_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            ebit_reg      <= ebit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        r_reg    <= r_next;
        bad_reg  <= bad_next;
        if (load_out)
        begin
            res_reg     <= r_reg;
            res_bad_reg <= bad_reg;
        end
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign result      = res_reg;
    assign bad_modulus = res_bad_reg;

`ifndef SYNTHESIS
    a_zero_mod_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && modulus_reg == '0) |=> (state_reg == S_FIN))
        else $error("Zero modulus item did not go straight to output.");
    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("Output raised outside the final state.");
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_bad_reg) |-> (res_reg == '0))
        else $error("Bad modulus item carries a nonzero result.");
    a_start_idle_mul: assert property (@(posedge clk) disable iff (!rst_n)
        mstart |-> !mstat.busy)
        else $error("Multiplier started while busy.");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/mexp_cell.sv
// One cell of the multiplier operand chain: holds one bit of the operand.
// Loads in parallel and hands its bit to the next cell on every shift.
`default_nettype none
module mexp_cell (
    input  wire logic clk,
    input  wire logic load,
    input  wire logic load_bit,
    input  wire logic shift,
    input  wire logic prev_bit,
    output logic      bit_out
);

    logic bit_reg;
    logic bit_next;

    always_comb
    begin
        bit_next = bit_reg;
        if (load)
        begin
            bit_next = load_bit;
        end
        else if (shift)
        begin
            bit_next = prev_bit;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_reg <= bit_next;
    end

    assign bit_out = bit_reg;

endmodule
`default_nettype wire

FILE: rtl/core/mexp_mul.sv
// Bit-serial modular multiplier: doubles and adds one operand bit per cycle.
// The second operand shifts through a chain of mexp_cell; uses mexp_pkg.
`default_nettype none
module mexp_mul
    import mexp_pkg::*;
#(
    parameter int W = 32
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [W-1:0]   a,
    input  wire logic [W-1:0]   b,
    input  wire logic [W-1:0]   n,
    output logic [W-1:0]        prod,
    output mexp_mul_stat_t      stat
);

    localparam int CW = $clog2(W);

    logic [W-1:0]  acc_reg;
    logic [W-1:0]  acc_next;
    logic [W-1:0]  a_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          busy_reg;
    logic          busy_next;
    logic          done_reg;
    logic          done_next;
    logic [W-1:0]  chain;
    logic [W-1:0]  dbl;

    function automatic logic [W-1:0] mod_add(input logic [W-1:0] x, input logic [W-1:0] y,
                                             input logic [W-1:0] m);
        logic [W:0] s;
        begin
            s = {1'b0, x} + {1'b0, y};
            if (s >= {1'b0, m})
            begin
                s = s - {1'b0, m};
            end
            mod_add = s[W-1:0];
        end
    endfunction

    for (genvar i = 0; i < W; i++)
    begin : g_cell
        mexp_cell u_cell (
            .clk      (clk),
            .load     (start),
            .load_bit (b[i]),
            .shift    (busy_reg),
            .prev_bit ((i == 0) ? 1'b0 : chain[(i == 0) ? 0 : i-1]),
            .bit_out  (chain[i])
        );
    end

    always_comb
    begin
        dbl       = mod_add(acc_reg, acc_reg, n);
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = chain[W-1] ? mod_add(dbl, a_reg, n) : dbl;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(W-1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (start)
        begin
            a_reg <= a;
        end
    end

    assign prod      = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
`default_nettype wire
